@@ rtl/ltkm_pkg.sv @@
// ----------------------------------------------------------------------------
// ltkm_pkg: shared constants for the loser tree k-way merge
// Widths of the item fields, tree dimensions, value limits and item modes.
// ----------------------------------------------------------------------------
package ltkm_pkg;

  // Tree dimensions: one leaf per source, one loser per internal node.
  localparam int unsigned WAYS   = 16;
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned NODE_W = $clog2(WAYS + 1);
  localparam int unsigned CNT_W  = 5;

  // Element values are signed two's complement.
  localparam int unsigned VAL_W = 32;
  localparam logic signed [VAL_W-1:0] END_VAL = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MIN_VAL = {1'b1, {(VAL_W-1){1'b0}}};

  // Item modes.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_BUILD  = 2'd1;
  localparam logic [1:0] MODE_REFILL = 2'd2;

endpackage

@@ rtl/loser_tree_kway_merge_top.sv @@
// ----------------------------------------------------------------------------
// loser_tree_kway_merge_top: k-way merge of sorted runs through a loser tree
// Leaf heads and tree losers live in two synchronous memories; a small
// sequencer replays the tree one level at a time.
// ----------------------------------------------------------------------------
// Usage:
// Input beats carry mode, source, value and exhausted. A load beat stores
// the head of one source and gives no result. A build beat replays every
// active leaf and gives the first winner. A refill beat replaces the last
// winner's head (the end value when exhausted) and gives the next winner.
// A refill before any build, or whose winner lies beyond the way count, is
// dropped without a result.
// The way count is written on the configuration channel, which is always
// ready; write it only while no beat is in flight.
// Replay: a load is written straight into the leaf memory. A refill climbs
// the L tree levels above the winner's leaf (4 at sixteen ways); each level
// takes one loser read and one key read. A build replays every active leaf
// in turn, from the highest leaf down.
// The result sits in an output register, so the next input beat is taken
// while it waits; if the receiver stalls, a later result waits in the
// sequencer until the register frees up.
// Reset empties the tree (no winner), sets the way count to sixteen and
// needs no clearing pass; heads are undefined until loaded.
// ----------------------------------------------------------------------------
module loser_tree_kway_merge_top
  import ltkm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [WAY_W-1:0]        source_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    exhausted_i,
  // Output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] winner_value_o,
  output logic [WAY_W-1:0]        winner_source_o,
  output logic                    done_res_o,
  // Configuration channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CNT_W-1:0]        active_ways_i
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_LEAF  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        ways_q;
  logic [CNT_W-1:0]        n_ways;
  logic [NODE_W-1:0]       leaf_cnt_q, leaf_cnt_d;
  logic [WAY_W-1:0]        par_q, par_d;
  logic [NODE_W-1:0]       cur_idx_q, cur_idx_d;
  logic signed [VAL_W-1:0] cur_val_q, cur_val_d;
  logic [NODE_W-1:0]       loser_q, loser_d;
  logic                    build_q, build_d;
  logic                    first_q, first_d;
  logic [NODE_W-1:0]       winner_q, winner_d;

  // Leaf memory ports.
  logic signed [VAL_W-1:0] leaf_mem [WAYS];
  logic                    leaf_we;
  logic [WAY_W-1:0]        leaf_waddr;
  logic signed [VAL_W-1:0] leaf_wdata;
  logic                    leaf_re;
  logic [WAY_W-1:0]        leaf_raddr;
  logic signed [VAL_W-1:0] leaf_rd_q;

  // Node memory ports and valid bits.
  logic [NODE_W-1:0]       node_mem [WAYS];
  logic [WAYS-1:0]         nv_q;
  logic                    nv_clear;
  logic                    node_we;
  logic                    node_re;
  logic [WAY_W-1:0]        node_raddr;
  logic [NODE_W-1:0]       node_rd_q;
  logic                    node_rv_q;

  // Output register.
  logic                    out_valid_q;
  logic                    out_load;
  logic signed [VAL_W-1:0] out_val_q;
  logic [WAY_W-1:0]        out_src_q;
  logic                    out_done_q;

  // Helper values.
  logic [CNT_W:0]          par_sum;
  logic [NODE_W-1:0]       cur_leaf_m1;
  logic [NODE_W-1:0]       loser_m1;
  logic [NODE_W-1:0]       win_m1;
  logic [NODE_W-1:0]       loser_now;
  logic signed [VAL_W-1:0] in_key;
  logic                    swap;
  logic                    fin;
  logic [WAY_W-1:0]        par_up;

  // Effective way count, clamped to one and to the tree size.
  always_comb begin
    if (ways_q == '0) begin
      n_ways = CNT_W'(1);
    end else if (ways_q > CNT_W'(WAYS)) begin
      n_ways = CNT_W'(WAYS);
    end else begin
      n_ways = ways_q;
    end
  end

  // The configuration register is always ready to take a beat.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= CNT_W'(WAYS);
    end else if (cfg_valid_i) begin
      ways_q <= active_ways_i;
    end
  end

  // Parent of the replayed leaf and the address arithmetic of the leaves.
  assign par_sum     = {1'b0, leaf_cnt_q} + {1'b0, n_ways} - (CNT_W+1)'(1);
  assign cur_leaf_m1 = leaf_cnt_q - NODE_W'(1);
  assign win_m1      = winner_q - NODE_W'(1);
  assign loser_now   = node_rv_q ? node_rd_q : '0;
  assign loser_m1    = loser_now - NODE_W'(1);
  assign in_key      = exhausted_i ? END_VAL : value_i;
  assign par_up      = par_q >> 1;

  // The replayed entry loses when it ranks strictly above the stored loser.
  assign swap = (cur_idx_q != '0) && ((loser_q == '0) || (cur_val_q > leaf_rd_q));

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer: takes input beats, issues memory reads, compares and writes back one level, and hands out the winner.
  always_comb begin
    state_d    = state_q;
    leaf_cnt_d = leaf_cnt_q;
    par_d      = par_q;
    cur_idx_d  = cur_idx_q;
    cur_val_d  = cur_val_q;
    loser_d    = loser_q;
    build_d    = build_q;
    first_d    = first_q;
    winner_d   = winner_q;
    leaf_we    = 1'b0;
    leaf_waddr = source_i;
    leaf_wdata = in_key;
    leaf_re    = 1'b0;
    leaf_raddr = cur_leaf_m1[WAY_W-1:0];
    node_re    = 1'b0;
    node_raddr = par_q;
    node_we    = 1'b0;
    nv_clear   = 1'b0;
    out_load   = 1'b0;
    fin        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_LOAD: begin
              leaf_we = 1'b1;
            end
            MODE_BUILD: begin
              nv_clear   = 1'b1;
              leaf_cnt_d = NODE_W'(n_ways);
              build_d    = 1'b1;
              state_d    = ST_START;
            end
            MODE_REFILL: begin
              if (winner_q != '0 && winner_q <= NODE_W'(n_ways)) begin
                leaf_we    = 1'b1;
                leaf_waddr = win_m1[WAY_W-1:0];
                cur_val_d  = in_key;
                leaf_cnt_d = winner_q;
                build_d    = 1'b0;
                state_d    = ST_START;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Read the first loser on the path, and the leaf's own key in a build.
      ST_START: begin
        par_d      = par_sum[WAY_W:1];
        node_raddr = par_sum[WAY_W:1];
        node_re    = 1'b1;
        leaf_re    = build_q;
        cur_idx_d  = leaf_cnt_q;
        first_d    = build_q;
        state_d    = ST_LEAF;
      end

      // The loser index is back: fetch its key.
      ST_LEAF: begin
        if (first_q) begin
          cur_val_d = leaf_rd_q;
          first_d   = 1'b0;
        end
        if (par_q == '0) begin
          fin = 1'b1;
        end else begin
          loser_d    = loser_now;
          leaf_raddr = loser_m1[WAY_W-1:0];
          leaf_re    = (loser_now != '0);
          state_d    = ST_CMP;
        end
      end

      // Compare, write back the loser and move one level up.
      ST_CMP: begin
        if (swap) begin
          node_we   = 1'b1;
          cur_idx_d = loser_q;
          cur_val_d = leaf_rd_q;
        end
        par_d = par_up;
        if (par_up != '0) begin
          node_raddr = par_up;
          node_re    = 1'b1;
          state_d    = ST_LEAF;
        end else begin
          fin = 1'b1;
        end
      end

      // Hand the winner to the output register once it is free.
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // End of one leaf-to-root replay.
    if (fin) begin
      winner_d = cur_idx_d;
      if (build_q && leaf_cnt_q > NODE_W'(1)) begin
        leaf_cnt_d = leaf_cnt_q - NODE_W'(1);
        state_d    = ST_START;
      end else begin
        state_d = ST_OUT;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      build_q  <= 1'b0;
      first_q  <= 1'b0;
      winner_q <= '0;
    end else begin
      state_q  <= state_d;
      build_q  <= build_d;
      first_q  <= first_d;
      winner_q <= winner_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    leaf_cnt_q <= leaf_cnt_d;
    par_q      <= par_d;
    cur_idx_q  <= cur_idx_d;
    cur_val_q  <= cur_val_d;
    loser_q    <= loser_d;
  end

  // Leaf memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    if (leaf_re) begin
      leaf_rd_q <= leaf_mem[leaf_raddr];
    end
  end

  // Node memory: a write at the current level, a read one level up.
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[par_q] <= cur_idx_q;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_raddr];
    end
  end

  // Node valid bits: an entry not yet written reads as the empty leaf.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q      <= '0;
      node_rv_q <= 1'b0;
    end else begin
      if (nv_clear) begin
        nv_q <= '0;
      end else if (node_we) begin
        nv_q[par_q] <= 1'b1;
      end
      if (node_re) begin
        node_rv_q <= nv_q[node_raddr];
      end
    end
  end

  // Source number of a leaf: leaf one is source zero.
  function automatic logic [WAY_W-1:0] cur_leaf_idx_m1(input logic [NODE_W-1:0] idx);
    logic [NODE_W-1:0] m1;
    m1 = idx - NODE_W'(1);
    return m1[WAY_W-1:0];
  endfunction

  // Output register: the empty leaf reports as the minimum value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= (cur_idx_q == '0) ? MIN_VAL : cur_val_q;
      out_src_q  <= cur_leaf_idx_m1(cur_idx_q);
      out_done_q <= (cur_idx_q != '0) && (cur_val_q == END_VAL);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign winner_value_o  = out_val_q;
  assign winner_source_o = out_src_q;
  assign done_res_o      = out_done_q;

endmodule

@@ dv/tb_loser_tree_kway_merge_top.sv @@
// ----------------------------------------------------------------------------
// tb_loser_tree_kway_merge_top: self-checking bench for the loser tree merge
// A scoreboard keeps its own copy of the leaf heads, the loser nodes and the
// winner, and predicts the winner for every build and every refill that is
// not dropped. Directed beats cover the value extremes, ties, every mode and
// the odd way counts. Randomised merges of sorted runs follow, with noise
// beats, random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_loser_tree_kway_merge_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ltkm_pkg::*;

  // Mode three carries no meaning and must be dropped by the block.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned BEAT_TARGET    = 1550;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RUN_MAX        = 12;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [WAY_W-1:0] src;
    logic             done;
  } winner_t;

  // Predicts the merge winner and holds the winners still owed by the block.
  class merge_scoreboard;
    logic signed [VAL_W-1:0] heads [WAYS];
    logic [NODE_W-1:0]       losers [WAYS];
    logic [NODE_W-1:0]       champ;
    logic [CNT_W-1:0]        ways_cfg;
    winner_t                 pending_winners [$];
    bit                      last_done;
    int                      mismatches;

    function new();
      foreach (heads[i]) heads[i] = '0;
      foreach (losers[i]) losers[i] = '0;
      champ      = '0;
      ways_cfg   = CNT_W'(WAYS);
      last_done  = 1'b0;
      mismatches = 0;
    endfunction

    function void note_config(logic [CNT_W-1:0] ways);
      ways_cfg = ways;
    endfunction

    // A count of zero behaves as one; anything above the tree size is clamped.
    function int way_count();
      int n;
      n = ways_cfg;
      if (n == 0) n = 1;
      if (n > WAYS) n = WAYS;
      return n;
    endfunction

    // Leaf zero is the virtual seed that ranks below everything.
    function logic signed [VAL_W-1:0] head_of(int leaf);
      if (leaf == 0 || leaf > WAYS) return MIN_VAL;
      return heads[leaf-1];
    endfunction

    function bit ranks_above(int a, int b);
      if (a == 0) return 1'b0;
      if (b == 0) return 1'b1;
      return head_of(a) > head_of(b);
    endfunction

    // Play one leaf up to the root; on a tie the climbing leaf carries on.
    function void replay_leaf(int leaf, int n);
      int cur;
      int up;
      int held;
      cur = leaf;
      up  = (leaf + n - 1) / 2;
      while (up > 0) begin
        if (up < WAYS && ranks_above(cur, losers[up])) begin
          held       = losers[up];
          losers[up] = NODE_W'(cur);
          cur        = held;
        end
        up = up / 2;
      end
      losers[0] = NODE_W'(cur);
      champ     = NODE_W'(cur);
    endfunction

    // Returns 1 when the beat owes a winner.
    function bit note_beat(logic [1:0] m, logic [WAY_W-1:0] s,
                           logic signed [VAL_W-1:0] v, logic e);
      int      n;
      int      i;
      winner_t w;
      n = way_count();
      case (m)
        MODE_LOAD: begin
          heads[s] = e ? END_VAL : v;
          return 1'b0;
        end
        MODE_BUILD: begin
          foreach (losers[k]) losers[k] = '0;
          for (i = n; i > 0; i--) replay_leaf(i, n);
        end
        MODE_REFILL: begin
          if (champ == 0 || champ > n) return 1'b0;
          heads[champ-1] = e ? END_VAL : v;
          replay_leaf(champ, n);
        end
        default: begin
          return 1'b0;
        end
      endcase
      w.value   = head_of(champ);
      w.src     = WAY_W'(champ - 1);
      w.done    = (head_of(champ) == END_VAL);
      last_done = w.done;
      pending_winners.push_back(w);
      return 1'b1;
    endfunction

    function void check_winner(logic signed [VAL_W-1:0] v, logic [WAY_W-1:0] s,
                               logic d);
      winner_t want;
      if (pending_winners.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: winner beat with none owed: value %0d source %0d done %0b",
                   $realtime, v, s, d);
        return;
      end
      want = pending_winners.pop_front();
      if (want.value != v || want.src != s || want.done != d) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: winner mismatch: expected value %0d source %0d done %0b, %s",
                   $realtime, $signed(want.value), want.src, want.done,
                   $sformatf("got value %0d source %0d done %0b", v, s, d));
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              mode = MODE_LOAD;
  logic [WAY_W-1:0]        source = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    exhausted = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] winner_value;
  logic [WAY_W-1:0]        winner_source;
  logic                    done_res;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_ways = CNT_W'(WAYS);

  merge_scoreboard sb = new();
  int unsigned     beats_used = 0;
  int unsigned     idle_cycles = 0;
  bit              calm = 1'b0;
  int              stall_left = 0;
  int              free_left = 0;
  int              stall_roll;

  loser_tree_kway_merge_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .source_i        (source),
    .value_i         (value),
    .exhausted_i     (exhausted),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .winner_value_o  (winner_value),
    .winner_source_o (winner_source),
    .done_res_o      (done_res),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .active_ways_i   (cfg_ways)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: runs of free cycles, short stalls and the odd long one.
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(99);
      if (stall_roll < 60) begin
        free_left = $urandom_range(6, 1);
        out_stall <= 1'b0;
      end else if (stall_roll < 92) begin
        stall_left = $urandom_range(2);
        out_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(40, 10);
        out_stall <= 1'b1;
      end
    end
  end

  // Every accepted winner beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_winner(winner_value, winner_source, done_res);
  end

  // Watchdog: too long without any beat on any channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [CNT_W-1:0] pick_ways();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return CNT_W'(WAYS);
    if (roll < 32) return CNT_W'(1);
    if (roll < 36) return '0;
    if (roll < 40) return CNT_W'($urandom_range(31, WAYS + 1));
    return CNT_W'($urandom_range(WAYS - 1, 2));
  endfunction

  // Offer one input beat and hold it until the block takes it.
  task automatic drive_beat(input logic [1:0] m, input logic [WAY_W-1:0] s,
                            input logic signed [VAL_W-1:0] v, input logic e);
    int gap;
    bit owed;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    source    <= s;
    value     <= v;
    exhausted <= e;
    do @(posedge clk_i); while (in_stall);
    owed = sb.note_beat(m, s, v, e);
    if (m == MODE_LOAD || owed) beats_used++;
  endtask

  task automatic drive_noise();
    drive_beat(2'($urandom_range(3)), WAY_W'($urandom), VAL_W'($urandom),
               1'($urandom_range(1)));
  endtask

  // Hold the sender until every owed winner has come, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_winners.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ways(input logic [CNT_W-1:0] ways);
    cfg_valid <= 1'b1;
    cfg_ways  <= ways;
    do @(posedge clk_i); while (!cfg_ready);
    sb.note_config(ways);
    cfg_valid <= 1'b0;
  endtask

  // One full merge: sorted runs per source, heads loaded, a build, then a
  // refill from whichever source won until every source is spent.
  task automatic run_merge(input logic [CNT_W-1:0] ways_setting);
    int                      n;
    int                      style;
    int                      src;
    int                      k;
    int                      start;
    int                      guard;
    int                      run_len [WAYS];
    int                      run_pos [WAYS];
    logic signed [VAL_W-1:0] run_val [WAYS][RUN_MAX];
    longint                  cur;
    wait_idle();
    calm = ($urandom_range(4) == 0);
    write_ways(ways_setting);
    n = (ways_setting == 0) ? 1 : ((ways_setting > WAYS) ? WAYS : int'(ways_setting));
    style = $urandom_range(2);
    for (src = 0; src < n; src++) begin
      run_len[src] = ($urandom_range(9) == 0) ? RUN_MAX : $urandom_range(6);
      run_pos[src] = 0;
      case (style)
        0:       cur = longint'($urandom_range(6)) - 3;
        1:       cur = longint'(MIN_VAL);
        default: cur = longint'($signed(VAL_W'($urandom)));
      endcase
      for (k = 0; k < run_len[src]; k++) begin
        run_val[src][k] = VAL_W'(cur);
        case (style)
          0:       cur += $urandom_range(1);
          1:       cur += $urandom;
          default: cur += $urandom_range(1 << 24);
        endcase
        if (cur > longint'(END_VAL)) cur = longint'(END_VAL);
      end
    end

    // Load the heads in a rotated order; some sources outside the count get junk.
    start = $urandom_range(WAYS - 1);
    for (k = 0; k < WAYS; k++) begin
      src = (start + k) % WAYS;
      if (src < n) begin
        if (run_len[src] == 0) begin
          drive_beat(MODE_LOAD, WAY_W'(src), VAL_W'($urandom), 1'b1);
        end else begin
          drive_beat(MODE_LOAD, WAY_W'(src), run_val[src][0], 1'b0);
          run_pos[src] = 1;
        end
      end else if ($urandom_range(3) == 0) begin
        drive_beat(MODE_LOAD, WAY_W'(src), VAL_W'($urandom), 1'($urandom_range(1)));
      end
    end
    drive_beat(MODE_BUILD, WAY_W'($urandom), VAL_W'($urandom), 1'($urandom_range(1)));

    guard = 0;
    while (!sb.last_done && guard < 400) begin
      guard++;
      if ($urandom_range(24) == 0) begin
        drive_noise();
      end else begin
        if (sb.champ == 0 || sb.champ > n) break;
        src = sb.champ - 1;
        if (run_pos[src] < run_len[src]) begin
          drive_beat(MODE_REFILL, WAY_W'($urandom), run_val[src][run_pos[src]], 1'b0);
          run_pos[src]++;
        end else begin
          drive_beat(MODE_REFILL, WAY_W'($urandom), VAL_W'($urandom), 1'b1);
        end
      end
    end
    // Up to two refills past the end of the merge follow, with random values and flags.
    repeat ($urandom_range(2))
      drive_beat(MODE_REFILL, WAY_W'($urandom), VAL_W'($urandom), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before any build a refill is dropped, as is the spare mode.
    drive_beat(MODE_REFILL, '0, MIN_VAL, 1'b0);
    drive_beat(MODE_SPARE, WAY_W'($urandom), VAL_W'($urandom), 1'b0);

    // Heads at the value extremes, an empty source and a tie on the minimum.
    for (int s = 0; s < WAYS; s++) begin
      case (s)
        0:       drive_beat(MODE_LOAD, WAY_W'(s), MIN_VAL, 1'b0);
        1:       drive_beat(MODE_LOAD, WAY_W'(s), END_VAL, 1'b0);
        2:       drive_beat(MODE_LOAD, WAY_W'(s), VAL_W'($urandom), 1'b1);
        3:       drive_beat(MODE_LOAD, WAY_W'(s), -1, 1'b0);
        4:       drive_beat(MODE_LOAD, WAY_W'(s), 0, 1'b0);
        5:       drive_beat(MODE_LOAD, WAY_W'(s), 1, 1'b0);
        15:      drive_beat(MODE_LOAD, WAY_W'(s), MIN_VAL, 1'b0);
        default: drive_beat(MODE_LOAD, WAY_W'(s), VAL_W'($urandom), 1'b0);
      endcase
    end
    drive_beat(MODE_BUILD, '0, '0, 1'b0);
    drive_beat(MODE_REFILL, '0, MIN_VAL, 1'b0);
    drive_beat(MODE_REFILL, '0, '0, 1'b1);
    drive_beat(MODE_REFILL, '0, END_VAL, 1'b0);

    // A single way, a zero count and an oversized count.
    wait_idle();
    write_ways(CNT_W'(1));
    drive_beat(MODE_BUILD, '0, '0, 1'b0);
    drive_beat(MODE_REFILL, '0, VAL_W'($urandom), 1'b0);
    wait_idle();
    write_ways('0);
    drive_beat(MODE_BUILD, '0, '0, 1'b0);
    drive_beat(MODE_REFILL, '0, '0, 1'b1);
    wait_idle();
    write_ways('1);
    drive_beat(MODE_BUILD, '0, '0, 1'b0);
    drive_beat(MODE_REFILL, '0, VAL_W'($urandom), 1'b0);

    // The count shrinks between a build and the following refill.
    wait_idle();
    write_ways(CNT_W'(WAYS));
    drive_beat(MODE_BUILD, '0, '0, 1'b0);
    wait_idle();
    write_ways(CNT_W'(3));
    drive_beat(MODE_REFILL, '0, VAL_W'($urandom), 1'b0);

    while (beats_used < BEAT_TARGET) run_merge(pick_ways());

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
